[rtl/aabb_affine_transform_assert.svh]
// ----------------------------------------------------------------------------
// aabb_affine_transform assertion macros
// shared property forms for the checker, clocked on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef AABB_AFFINE_TRANSFORM_ASSERT_SVH
`define AABB_AFFINE_TRANSFORM_ASSERT_SVH

// same-cycle implication
`define AABB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("aabb_affine_transform: property failed");

// next-cycle implication
`define AABB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("aabb_affine_transform: property failed");

`endif

[rtl/aabb_xf_pkg.sv]
// ----------------------------------------------------------------------------
// aabb_xf_pkg
// widths, types and constants of the transformed bounding box block
// ----------------------------------------------------------------------------
package aabb_xf_pkg;

  localparam int CoordWidth = 24;
  localparam int PadWidth   = 23;
  localparam int CoefWidth  = 16;
  localparam int CoefFrac   = 14;
  localparam int NumAxes    = 3;
  localparam int RowWidth   = NumAxes * CoefWidth;

  // widened box corner, product, accumulator and shifted-down quotient
  localparam int WideWidth  = CoordWidth + 1;
  localparam int ProdWidth  = WideWidth + CoefWidth;
  localparam int AccWidth   = ProdWidth + 2;
  localparam int QuotWidth  = AccWidth - CoefFrac;

  // stream packing
  localparam int InBits        = 3 * NumAxes * CoordWidth + NumAxes * RowWidth;
  localparam int InTdataWidth  = ((InBits + 7) / 8) * 8;
  localparam int OutBits       = 2 * NumAxes * CoordWidth;
  localparam int OutTdataWidth = ((OutBits + 7) / 8) * 8;

  localparam int RowBase   = 2 * NumAxes * CoordWidth;
  localparam int ShiftBase = RowBase + NumAxes * RowWidth;

  localparam int NumStages = 5;

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic signed [WideWidth-1:0]  wide_t;
  typedef logic signed [CoefWidth-1:0]  coef_t;
  typedef logic signed [ProdWidth-1:0]  prod_t;
  typedef logic signed [AccWidth-1:0]   acc_t;
  typedef logic signed [QuotWidth-1:0]  quot_t;
  typedef logic [PadWidth-1:0]          pad_t;

  localparam pad_t   PadReset  = PadWidth'(256);
  localparam coord_t CoordMax  = coord_t'((64'sd1 <<< (CoordWidth - 1)) - 64'sd1);
  localparam coord_t CoordMin  = coord_t'(-(64'sd1 <<< (CoordWidth - 1)));
  localparam quot_t  QuotMax   = quot_t'((64'sd1 <<< (CoordWidth - 1)) - 64'sd1);
  localparam quot_t  QuotMin   = quot_t'(-(64'sd1 <<< (CoordWidth - 1)));
  localparam acc_t   RoundBias = acc_t'((64'sd1 <<< CoefFrac) - 64'sd1);

endpackage

[rtl/aabb_affine_transform.sv]
// ----------------------------------------------------------------------------
// aabb_affine_transform
// bounds of an axis-aligned box after an affine transform, one box per beat
// ----------------------------------------------------------------------------
//
//  channel   | direction | payload
//  ----------+-----------+---------------------------------------------------
//  cfg       | in        | degenerate pad, 23 bit unsigned Q15.8
//  s_axis    | in        | box min/max, three Q2.14 rows, translation
//  m_axis    | out       | min and max of the transformed corners
//
//  five register stages: widen, multiply, term select, sum, round/saturate
//  a new box enters every cycle while the output is not stalled, throughput set by the 18 parallel multipliers
//  each stage holds its own valid bit, bubbles close up under back pressure
//  reset clears the valid bits and loads the pad with 1.0; no clearing pass
//
// ----------------------------------------------------------------------------
module aabb_affine_transform
  import aabb_xf_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration write
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [PadWidth-1:0]      cfg_data_i,     // degenerate_pad
  // box stream in
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
  // linear_row_x, linear_row_y, linear_row_z, shift_x, shift_y, shift_z
  input  logic [InTdataWidth-1:0]  s_axis_tdata,
  // bounds stream out
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // out_min_x, out_min_y, out_min_z, out_max_x, out_max_y, out_max_z
  output logic [OutTdataWidth-1:0] m_axis_tdata
);

  // --------------------------------------------------------------------------
  // pad register, to be written only while the block is idle; the block does not enforce this
  // --------------------------------------------------------------------------
  pad_t pad_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pad_q <= PadReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      pad_q <= cfg_data_i;
    end
  end

  // --------------------------------------------------------------------------
  // pipeline flow control: a stage moves when it is empty or its successor moves
  // --------------------------------------------------------------------------
  logic [NumStages-1:0] vld_q;
  logic [NumStages-1:0] stage_en;

  always_comb begin
    stage_en[NumStages-1] = !vld_q[NumStages-1] || m_axis_tready;
    for (int s = NumStages - 2; s >= 0; s--) begin
      stage_en[s] = !vld_q[s] || stage_en[s+1];
    end
  end

  assign s_axis_tready = stage_en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (stage_en[0]) begin
        vld_q[0] <= s_axis_tvalid;
      end
      for (int s = 1; s < NumStages; s++) begin
        if (stage_en[s]) begin
          vld_q[s] <= vld_q[s-1];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 0: unpack, widen zero-extent axes by the pad
  // --------------------------------------------------------------------------
  wide_t  lo_d [NumAxes];
  wide_t  hi_d [NumAxes];
  coef_t  coef_d [NumAxes][NumAxes];
  coord_t shift_d [NumAxes];

  wide_t  lo_q [NumAxes];
  wide_t  hi_q [NumAxes];
  coef_t  coef_q [NumAxes][NumAxes];
  coord_t shift_s0_q [NumAxes];

  wide_t pad_w;
  assign pad_w = wide_t'($signed({1'b0, pad_q}));

  always_comb begin
    for (int a = 0; a < NumAxes; a++) begin
      lo_d[a] = wide_t'($signed(s_axis_tdata[a*CoordWidth +: CoordWidth]));
      hi_d[a] = wide_t'($signed(s_axis_tdata[(NumAxes+a)*CoordWidth +: CoordWidth]));
      // zero extent: grow both sides, kept exact at one extra bit
      if (lo_d[a] == hi_d[a]) begin
        lo_d[a] = lo_d[a] - pad_w;
        hi_d[a] = hi_d[a] + pad_w;
      end
      // row a feeds output axis a; its low coefficient multiplies x
      for (int k = 0; k < NumAxes; k++) begin
        coef_d[a][k] = $signed(s_axis_tdata[RowBase + a*RowWidth + k*CoefWidth +: CoefWidth]);
      end
      shift_d[a] = $signed(s_axis_tdata[ShiftBase + a*CoordWidth +: CoordWidth]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[0]) begin
      lo_q       <= lo_d;
      hi_q       <= hi_d;
      coef_q     <= coef_d;
      shift_s0_q <= shift_d;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: each coefficient times both candidate coordinates
  // --------------------------------------------------------------------------
  prod_t  plo_d [NumAxes][NumAxes];
  prod_t  phi_d [NumAxes][NumAxes];
  prod_t  plo_q [NumAxes][NumAxes];
  prod_t  phi_q [NumAxes][NumAxes];
  coord_t shift_s1_q [NumAxes];

  always_comb begin
    for (int i = 0; i < NumAxes; i++) begin
      for (int k = 0; k < NumAxes; k++) begin
        plo_d[i][k] = prod_t'(coef_q[i][k]) * prod_t'(lo_q[k]);
        phi_d[i][k] = prod_t'(coef_q[i][k]) * prod_t'(hi_q[k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[1]) begin
      plo_q      <= plo_d;
      phi_q      <= phi_d;
      shift_s1_q <= shift_s0_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: terms are separable over the corners, so the extreme corner
  // picks the smaller and larger product per term independently
  // --------------------------------------------------------------------------
  prod_t  tmin_d [NumAxes][NumAxes];
  prod_t  tmax_d [NumAxes][NumAxes];
  prod_t  tmin_q [NumAxes][NumAxes];
  prod_t  tmax_q [NumAxes][NumAxes];
  coord_t shift_s2_q [NumAxes];

  always_comb begin
    for (int i = 0; i < NumAxes; i++) begin
      for (int k = 0; k < NumAxes; k++) begin
        if (plo_q[i][k] < phi_q[i][k]) begin
          tmin_d[i][k] = plo_q[i][k];
          tmax_d[i][k] = phi_q[i][k];
        end else begin
          tmin_d[i][k] = phi_q[i][k];
          tmax_d[i][k] = plo_q[i][k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[2]) begin
      tmin_q     <= tmin_d;
      tmax_q     <= tmax_d;
      shift_s2_q <= shift_s1_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: sum terms plus translation in Q.22
  // --------------------------------------------------------------------------
  acc_t amin_d [NumAxes];
  acc_t amax_d [NumAxes];
  acc_t amin_q [NumAxes];
  acc_t amax_q [NumAxes];
  acc_t shift_acc [NumAxes];

  always_comb begin
    for (int i = 0; i < NumAxes; i++) begin
      shift_acc[i] = acc_t'(shift_s2_q[i]);
      amin_d[i] = acc_t'(tmin_q[i][0]) + acc_t'(tmin_q[i][1]) + acc_t'(tmin_q[i][2])
                + (shift_acc[i] <<< CoefFrac);
      amax_d[i] = acc_t'(tmax_q[i][0]) + acc_t'(tmax_q[i][1]) + acc_t'(tmax_q[i][2])
                + (shift_acc[i] <<< CoefFrac);
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[3]) begin
      amin_q <= amin_d;
      amax_q <= amax_d;
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: truncate toward zero to Q16.8 and saturate; both steps are
  // monotone, so the extremes of the sums stay the extremes of the results
  // --------------------------------------------------------------------------
  function automatic coord_t trunc_sat(acc_t acc);
    acc_t  biased;
    quot_t q;
    biased = acc + (acc[AccWidth-1] ? RoundBias : acc_t'(0));
    q      = quot_t'(biased >>> CoefFrac);
    if (q > QuotMax) begin
      return CoordMax;
    end else if (q < QuotMin) begin
      return CoordMin;
    end
    return coord_t'(q);
  endfunction

  logic [OutBits-1:0] out_d;
  logic [OutBits-1:0] out_q;

  always_comb begin
    for (int i = 0; i < NumAxes; i++) begin
      out_d[i*CoordWidth +: CoordWidth]           = trunc_sat(amin_q[i]);
      out_d[(NumAxes+i)*CoordWidth +: CoordWidth] = trunc_sat(amax_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[4]) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = vld_q[NumStages-1];
  assign m_axis_tdata  = OutTdataWidth'(out_q);

endmodule

[rtl/aabb_xf_checker.sv]
// ----------------------------------------------------------------------------
// aabb_xf_checker
// port-level checks of the transformed bounding box block
// ----------------------------------------------------------------------------
`include "aabb_affine_transform_assert.svh"

module aabb_xf_checker
  import aabb_xf_pkg::*;
(
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     s_axis_tvalid,
  input logic                     s_axis_tready,
  input logic                     m_axis_tvalid,
  input logic                     m_axis_tready,
  input logic [OutTdataWidth-1:0] m_axis_tdata
);

  coord_t mn_x, mn_y, mn_z, mx_x, mx_y, mx_z;
  assign mn_x = $signed(m_axis_tdata[0*CoordWidth +: CoordWidth]);
  assign mn_y = $signed(m_axis_tdata[1*CoordWidth +: CoordWidth]);
  assign mn_z = $signed(m_axis_tdata[2*CoordWidth +: CoordWidth]);
  assign mx_x = $signed(m_axis_tdata[3*CoordWidth +: CoordWidth]);
  assign mx_y = $signed(m_axis_tdata[4*CoordWidth +: CoordWidth]);
  assign mx_z = $signed(m_axis_tdata[5*CoordWidth +: CoordWidth]);

  // a stalled result beat stays put
  `AABB_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // the lower bound never passes the upper bound on any axis
  `AABB_ASSERT_NOW(a_min_le_max, m_axis_tvalid, (mn_x <= mx_x) && (mn_y <= mx_y) && (mn_z <= mx_z))

  // with no result waiting the pipeline always has room
  `AABB_ASSERT_NOW(a_ready_when_empty, !m_axis_tvalid, s_axis_tready)

  // an accepted beat reaches the output through an unstalled pipeline
  `AABB_ASSERT_NEXT(a_latency, (s_axis_tvalid && s_axis_tready) ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready, m_axis_tvalid)

endmodule

bind aabb_affine_transform aabb_xf_checker u_aabb_xf_checker (.*);
